FILE: rtl/core/mesh_route_learning_table_macros.svh
// Assertion helpers used by the checker file.
`ifndef MESH_ROUTE_LEARNING_TABLE_MACROS_SVH
`define MESH_ROUTE_LEARNING_TABLE_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define MRLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrlt assertion failed");

// Next-cycle implication, inactive while reset is asserted.
`define MRLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrlt assertion failed");

`endif

FILE: rtl/core/mrlt_pkg.sv
package mrlt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OUT_IDX_W     = 4;

    localparam logic [1:0] FUNC_LEARN  = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] ST_REFRESHED = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_DROPPED   = 2'd2;
    localparam logic [1:0] ST_OTHER     = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] neighbor_addr;
        logic [15:0] origin_addr;
        logic [15:0] dest_addr;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [15:0]          next_hop;
        logic [OUT_IDX_W-1:0] entry_index;
        logic [1:0]           learn_status;
    } t_rsp;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic             valid;
        t_req             req;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [15:0]      hop;
        logic             spare;
        logic [IDX_W-1:0] spare_idx;
    } t_tok;

    // Insert command broadcast to every cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        logic [15:0]      neighbor_addr;
        logic [15:0]      origin_addr;
        logic [31:0]      now_time;
    } t_wr;

    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = (IDX_W + OUT_IDX_W)'(idx);
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/mrlt_intf.sv
interface mrlt_req_if;
    import mrlt_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mrlt_rsp_if;
    import mrlt_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/mrlt_cell.sv
module mrlt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mrlt_pkg::IDX_W-1:0] i_slot_id,
    input  mrlt_pkg::t_tok             i_tok,
    input  mrlt_pkg::t_wr              i_wr,
    output mrlt_pkg::t_tok             o_tok
);
    import mrlt_pkg::*;

    logic        r_valid;
    logic [15:0] r_neighbor;
    logic [15:0] r_origin;
    logic [31:0] r_time;
    t_tok        r_tok;
    t_tok        n_tok;
    logic        w_touch;
    logic        w_clear;
    logic        w_insert;

    assign w_clear  = i_tok.valid && (i_tok.req.func == FUNC_CLEAR);
    assign w_insert = i_wr.en && (i_wr.slot == i_slot_id);

    always_comb begin
        n_tok   = i_tok;
        w_touch = 1'b0;
        if (i_tok.valid) begin
            case (i_tok.req.func)
                FUNC_LEARN: begin
                    if (r_valid) begin
                        if (!i_tok.found && r_neighbor == i_tok.req.neighbor_addr
                                && r_origin == i_tok.req.origin_addr) begin
                            n_tok.found     = 1'b1;
                            n_tok.found_idx = i_slot_id;
                            w_touch         = 1'b1;
                        end
                    end else if (!i_tok.spare) begin
                        n_tok.spare     = 1'b1;
                        n_tok.spare_idx = i_slot_id;
                    end
                end
                FUNC_LOOKUP: begin
                    if (!i_tok.found && r_valid && r_origin == i_tok.req.dest_addr) begin
                        n_tok.found     = 1'b1;
                        n_tok.found_idx = i_slot_id;
                        n_tok.hop       = r_neighbor;
                        w_touch         = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_clear) begin
                r_valid <= 1'b0;
            end else if (w_insert) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_neighbor <= '0;
            r_origin   <= '0;
            r_time     <= '0;
        end else if (w_insert) begin
            r_neighbor <= i_wr.neighbor_addr;
            r_origin   <= i_wr.origin_addr;
            r_time     <= i_wr.now_time;
        end else if (w_touch) begin
            r_time <= i_tok.req.now_time;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/core/mesh_route_learning_table.sv
// Route table of TABLE_ENTRIES slots kept as a chain of cells, one slot per
// cell. Each transaction travels down the chain one cell per clock, passing
// the launch register, the token register of each cell and a finish register
// before its outcome is resolved into the output register. The request side
// accepts no new transaction until the current result has been loaded into
// the output register; a result still waiting in the output register when
// the next scan finishes stalls that transaction until the result is taken.
// Learn refreshes the lowest matching slot, inserts into the lowest free one
// or is dropped when no slot is free; lookup returns the lowest slot whose
// origin equals the destination, clear empties the table. A finished result
// may wait in the output register while the next transaction is scanned.
module mesh_route_learning_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrlt_req_if.sink   i_req,
    mrlt_rsp_if.source o_rsp
);
    import mrlt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    t_tok   r_launch;
    t_tok   n_launch;
    t_tok   r_fin;
    t_tok   w_tok [TABLE_ENTRIES];
    t_tok   w_last;
    t_wr    w_wr;
    t_rsp   r_out;
    t_rsp   n_rsp;
    logic   r_out_valid;
    logic   w_acc;
    logic   w_out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_last      = w_tok[TABLE_ENTRIES-1];

    always_comb begin
        n_launch       = '0;
        n_launch.valid = w_acc;
        n_launch.req   = i_req.data;
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            mrlt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_slot_id (IDX_W'(k)),
                .i_tok     ((k == 0) ? r_launch : w_tok[(k == 0) ? 0 : k - 1]),
                .i_wr      (w_wr),
                .o_tok     (w_tok[k])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = S_SCAN;
            S_SCAN: if (w_last.valid) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Resolve the scan outcome and decide on an insert.
    always_comb begin
        n_rsp              = '0;
        n_rsp.learn_status = ST_OTHER;
        w_wr               = '0;
        w_wr.slot          = r_fin.spare_idx;
        w_wr.neighbor_addr = r_fin.req.neighbor_addr;
        w_wr.origin_addr   = r_fin.req.origin_addr;
        w_wr.now_time      = r_fin.req.now_time;
        case (r_fin.req.func)
            FUNC_LEARN: begin
                if (r_fin.found) begin
                    n_rsp.learn_status = ST_REFRESHED;
                    n_rsp.entry_index  = to_out_idx(r_fin.found_idx);
                end else if (r_fin.spare) begin
                    n_rsp.learn_status = ST_INSERTED;
                    n_rsp.entry_index  = to_out_idx(r_fin.spare_idx);
                    w_wr.en            = (r_state == S_DONE) && w_out_free;
                end else begin
                    n_rsp.learn_status = ST_DROPPED;
                end
            end
            FUNC_LOOKUP: begin
                if (r_fin.found) begin
                    n_rsp.hit         = 1'b1;
                    n_rsp.next_hop    = r_fin.hop;
                    n_rsp.entry_index = to_out_idx(r_fin.found_idx);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_launch.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && w_last.valid) begin
            r_fin <= w_last;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

FILE: rtl/core/mrlt_checker.sv
`include "mesh_route_learning_table_macros.svh"

module mrlt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input mrlt_pkg::t_rsp i_rsp_data
);
    import mrlt_pkg::*;

    // A stalled result holds.
    `MRLT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))
    // One transaction in the chain at a time.
    `MRLT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    // Learn results never report a hit.
    `MRLT_ASSERT_NOW(a_learn_no_hit, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.learn_status != ST_OTHER, !i_rsp_data.hit && i_rsp_data.next_hop == 16'd0)
    // Misses and other operations carry no slot and no next hop.
    `MRLT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.learn_status == ST_OTHER && !i_rsp_data.hit, i_rsp_data.next_hop == 16'd0 && i_rsp_data.entry_index == '0)
    // A dropped learn touches no slot.
    `MRLT_ASSERT_NOW(a_drop_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.learn_status == ST_DROPPED, i_rsp_data.entry_index == '0)

endmodule

bind mesh_route_learning_table mrlt_checker u_mrlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
